FILE: rtl/ps2_mouse_packet_cursor_assert.svh
// assertion macros used by the checker file
`ifndef PS2_MOUSE_PACKET_CURSOR_ASSERT_SVH
`define PS2_MOUSE_PACKET_CURSOR_ASSERT_SVH

// implication checked in the same cycle, skipped while in reset
`define PMPC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pmpc assertion failed");

// implication checked in the next cycle, skipped while in reset
`define PMPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pmpc assertion failed");

// implication checked in the next cycle, also across reset
`define PMPC_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("pmpc assertion failed");

`endif

FILE: rtl/pmpc_pkg.sv
`default_nettype none
package pmpc_pkg;

   localparam int COORD_BITS_DEFAULT = 12;
   localparam int SIZE_W = 13;
   localparam int BYTE_W = 8;

   typedef logic [0:0]        csr_index_type;
   typedef logic [SIZE_W-1:0] size_type;
   typedef logic [BYTE_W-1:0] byte_type;

   localparam csr_index_type CSR_SCREEN_WIDTH  = 1'd0;
   localparam csr_index_type CSR_SCREEN_HEIGHT = 1'd1;

   localparam size_type WIDTH_RESET  = 13'd640;
   localparam size_type HEIGHT_RESET = 13'd480;

   // status byte bit positions
   localparam int BIT_LEFT  = 0;
   localparam int BIT_XSIGN = 4;
   localparam int BIT_YSIGN = 5;
   localparam int BIT_XOVF  = 6;
   localparam int BIT_YOVF  = 7;

endpackage
`default_nettype wire

FILE: rtl/ps2_mouse_packet_cursor.sv
// PS/2 mouse packet decoder with a clamped cursor.
// Input channel (req_): one raw mouse byte per transaction, taken when
// req_valid is high and req_stall is low. The first byte after reset is the
// mouse acknowledge and is dropped; later bytes form status / x / y packets
// by position alone.
// Result channel (rsp_): on the third byte of a packet without overflow bits
// the cursor moves (x plus, y minus the 9-bit deltas), each axis saturates to
// 0..size-1 (capped at the coordinate range), and one transaction carries cursor x, cursor y and the left
// button. Overflow packets are consumed and give nothing.
// Configuration (csr_): screen width (index 0) and height (index 1), always
// ready; written only while idle, which the block itself does not enforce.
// Result timing: the result is registered and appears in the cycle after its third byte is accepted.
// Throughput: one byte per cycle while no result waits under rsp_stall; all
// decode and clamp logic sits between the packet state registers and the result register.
// Reset: sizes go to 640 x 480, cursor to 0,0, the acknowledge skip is armed.
// Stall: while a result waits under rsp_stall, req_stall is raised and no
// byte is taken; the result register holds.
`default_nettype none
module ps2_mouse_packet_cursor #(
   parameter int COORD_BITS = pmpc_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire pmpc_pkg::byte_type     req_packet_byte,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [COORD_BITS-1:0]       rsp_cursor_x,
   output logic [COORD_BITS-1:0]       rsp_cursor_y,
   output logic                        rsp_left_pressed,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire pmpc_pkg::csr_index_type csr_index,
   input  wire pmpc_pkg::size_type     csr_data
);
   import pmpc_pkg::*;

   localparam int C = COORD_BITS;
   // compare width wide enough for both a size and a coordinate
   localparam int LW = ((C > SIZE_W) ? C : SIZE_W) + 1;
   localparam logic [C-1:0] COORD_MAX = '1;

   typedef enum logic [1:0] {
      POS_STATUS,
      POS_X,
      POS_Y
   } pos_type;

   pos_type          byte_pos_ff, byte_pos_in;
   logic             skip_ff, skip_in;
   byte_type         status_ff, status_in;
   byte_type         xbyte_ff, xbyte_in;
   logic [C-1:0]     pos_x_ff, pos_x_in;
   logic [C-1:0]     pos_y_ff, pos_y_in;
   size_type         width_ff, width_in;
   size_type         height_ff, height_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [C-1:0]     cur_x_ff, cur_x_in;
   logic [C-1:0]     cur_y_ff, cur_y_in;
   logic             left_ff, left_in;

   logic             accept;
   logic             produce;
   logic [C+1:0]     dx, dy;
   logic [C+1:0]     nx, ny;
   logic [C-1:0]     lim_x, lim_y;
   logic [C-1:0]     clamp_x, clamp_y;

   // size to clamped limit: zero size acts as one, limit capped at the coord range
   function automatic logic [C-1:0] size_limit(input size_type size);
      logic [LW-1:0] lim;
      lim = (size == '0) ? '0 : LW'(size - SIZE_W'(1));
      if (lim > LW'(COORD_MAX)) begin
         return COORD_MAX;
      end
      return lim[C-1:0];
   endfunction

   function automatic logic [C-1:0] clamp(input logic [C+1:0] v, input logic [C-1:0] lim);
      if (v[C+1]) begin
         return '0;
      end
      if (v[C:0] > {1'b0, lim}) begin
         return lim;
      end
      return v[C-1:0];
   endfunction

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign produce = accept && !skip_ff && (byte_pos_ff == POS_Y)
                    && !status_ff[BIT_XOVF] && !status_ff[BIT_YOVF];

   // 9-bit deltas, sign from the status byte, extended to the sum width
   assign dx = {{(C - 6){status_ff[BIT_XSIGN]}}, xbyte_ff};
   assign dy = {{(C - 6){status_ff[BIT_YSIGN]}}, req_packet_byte};
   assign nx = {2'b00, pos_x_ff} + dx;
   assign ny = {2'b00, pos_y_ff} - dy;

   assign lim_x   = size_limit(width_ff);
   assign lim_y   = size_limit(height_ff);
   assign clamp_x = clamp(nx, lim_x);
   assign clamp_y = clamp(ny, lim_y);

   always_comb begin
      skip_in     = skip_ff;
      byte_pos_in = byte_pos_ff;
      status_in   = status_ff;
      xbyte_in    = xbyte_ff;
      pos_x_in    = pos_x_ff;
      pos_y_in    = pos_y_ff;
      if (accept) begin
         if (skip_ff) begin
            skip_in = 1'b0;
         end else begin
            case (byte_pos_ff)
               POS_STATUS: begin
                  status_in   = req_packet_byte;
                  byte_pos_in = POS_X;
               end
               POS_X: begin
                  xbyte_in    = req_packet_byte;
                  byte_pos_in = POS_Y;
               end
               default: begin
                  byte_pos_in = POS_STATUS;
               end
            endcase
         end
      end
      if (produce) begin
         pos_x_in = clamp_x;
         pos_y_in = clamp_y;
      end
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SCREEN_WIDTH:  width_in  = csr_data;
            CSR_SCREEN_HEIGHT: height_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      left_in      = left_ff;
      if (produce) begin
         rsp_valid_in = 1'b1;
         cur_x_in     = clamp_x;
         cur_y_in     = clamp_y;
         left_in      = status_ff[BIT_LEFT];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skip_ff      <= 1'b1;
         byte_pos_ff  <= POS_STATUS;
         status_ff    <= '0;
         xbyte_ff     <= '0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         skip_ff      <= skip_in;
         byte_pos_ff  <= byte_pos_in;
         status_ff    <= status_in;
         xbyte_ff     <= xbyte_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff <= cur_x_in;
      cur_y_ff <= cur_y_in;
      left_ff  <= left_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cursor_x     = cur_x_ff;
   assign rsp_cursor_y     = cur_y_ff;
   assign rsp_left_pressed = left_ff;

endmodule
`default_nettype wire

FILE: rtl/pmpc_checker.sv
`default_nettype none
`include "ps2_mouse_packet_cursor_assert.svh"
module pmpc_checker #(
   parameter int COORD_BITS = pmpc_pkg::COORD_BITS_DEFAULT
) (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_valid,
   input wire logic                    req_stall,
   input wire pmpc_pkg::byte_type      req_packet_byte,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_stall,
   input wire logic [COORD_BITS-1:0]   rsp_cursor_x,
   input wire logic [COORD_BITS-1:0]   rsp_cursor_y,
   input wire logic                    rsp_left_pressed,
   input wire logic                    csr_valid,
   input wire logic                    csr_ready,
   input wire pmpc_pkg::csr_index_type csr_index,
   input wire pmpc_pkg::size_type      csr_data
);
   import pmpc_pkg::*;

   logic     rsp_hold;
   logic     req_take;
   logic     unused_ok;
   byte_type unused_byte;

   assign rsp_hold    = rsp_valid && rsp_stall;
   assign req_take    = req_valid && !req_stall;
   assign unused_byte = req_packet_byte;
   assign unused_ok   = ^{unused_byte, csr_valid, csr_ready, csr_index, csr_data};

   // a stalled result keeps its fields
   `PMPC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_hold,
      rsp_valid && $stable(rsp_cursor_x) && $stable(rsp_cursor_y) && $stable(rsp_left_pressed))

   // nothing comes out the cycle after reset
   `PMPC_ASSERT_NEXT_ALWAYS(a_reset_quiet, clock, reset, !rsp_valid)

   // input is held off only behind a stalled result
   `PMPC_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_hold)

   // every fresh result follows a byte taken in the cycle before
   `PMPC_ASSERT_NOW(a_rsp_source, clock, reset, rsp_valid && !$past(rsp_hold),
      $past(req_take))

endmodule

bind ps2_mouse_packet_cursor pmpc_checker #(.COORD_BITS(COORD_BITS)) u_pmpc_checker (.*);
`default_nettype wire
